/* design/hss_pkg.sv */
// Shared types and constants for the heat stencil sweep block.
`default_nettype none

package hss_pkg;

    // Line store depth and the widths that follow from it.
    localparam int MAX_COLS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);

    // Grid and field widths.
    localparam int MAX_ROWS   = 4096;
    localparam int MIN_DIM    = 3;
    localparam int ROW_W      = 12;
    localparam int TEMP_W     = 32;
    localparam int CFL_W      = 16;
    localparam int ROWCNT_W   = 13;
    localparam int COLCNT_W   = 11;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Arithmetic widths: the neighbor sum needs three guard bits, the
    // product adds the unsigned coefficient with its sign bit.
    localparam int FRAC_W       = 16;
    localparam int CENTER_SHIFT = 2;
    localparam int SUM_W        = TEMP_W + 3;
    localparam int PROD_W       = SUM_W + CFL_W + 1;
    localparam int QUO_W        = PROD_W - FRAC_W;
    localparam int RES_W        = QUO_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [RES_W-1:0]  TEMP_MAX   = RES_W'(2147483647);
    localparam logic signed [RES_W-1:0]  TEMP_MIN   = -(RES_W'(2147483647)) - RES_W'(1);

    // Result queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 2'd0,
        CFG_COL_COUNT = 2'd1,
        CFG_CFL_COEFF = 2'd2
    } cfg_reg_t;

    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST = 13'd64;
    localparam logic [COLCNT_W-1:0] COL_COUNT_RST = 11'd64;
    localparam logic [CFL_W-1:0]    CFL_COEFF_RST = 16'd16384;

    // One result beat.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     run_end;
        logic                     frame_end;
    } result_t;

endpackage

`default_nettype wire

/* design/hss_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module hss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

/* design/heat_stencil_sweep.sv */
// Top level of the heat stencil sweep: one Jacobi pass of a five-point stencil.
//
// Grid temperatures (signed Q16.16) enter on the cell_temp channel in raster
// order, one beat per cell. Each cell of row r >= 1 produces the updated cell
// (r-1, c); cells of the last row produce that beat and then themselves. Cells
// of the first row produce nothing. Border cells pass through unchanged.
// The configuration port writes row_count, col_count and cfl_coeff; the user
// must write them only while the block is idle, which the block does not
// enforce. Any write to one of them restarts the frame at row 0. Throughput
// is one input beat per cycle while in_stall is low, set by the two line stores,
// each read once and written once per cycle. On the last row each input beat
// yields two result beats, so there the output port limits the input rate. The
// first result of an input beat passes the operand register, sum, product,
// and round and saturate into the result queue. An eight-beat result queue
// sits between the pipeline and the output; in_stall rises when the queue
// could not take the results of one more beat, so a stalled receiver backs
// up into the input after a few beats, never losing or repeating a result.
// Reset clears the position counters, the queue and the pipeline and loads
// the default configuration; the line stores keep old contents, which only
// ever feed border cells and are overwritten before they matter.
`default_nettype none

module heat_stencil_sweep (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               cfg_we,
    input  wire logic [hss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hss_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [hss_pkg::TEMP_W-1:0]  cell_temp,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [hss_pkg::TEMP_W-1:0]       new_temp,
    output logic [hss_pkg::ROW_W-1:0]               row_index,
    output logic [hss_pkg::COL_W-1:0]               col_index,
    output logic                                    run_end,
    output logic                                    frame_end
);

    localparam int COL_W  = hss_pkg::COL_W;
    localparam int ROW_W  = hss_pkg::ROW_W;
    localparam int TEMP_W = hss_pkg::TEMP_W;
    localparam int SUM_W  = hss_pkg::SUM_W;
    localparam int PROD_W = hss_pkg::PROD_W;
    localparam int QUO_W  = hss_pkg::QUO_W;
    localparam int RES_W  = hss_pkg::RES_W;
    localparam int PTR_W  = hss_pkg::FIFO_PTR_W;
    localparam int CNT_W  = hss_pkg::FIFO_CNT_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [hss_pkg::ROWCNT_W-1:0] row_count_reg;
    logic [hss_pkg::COLCNT_W-1:0] col_count_reg;
    logic [hss_pkg::CFL_W-1:0]    cfl_coeff_reg;
    logic                         cfg_hit;

    always_comb
    begin
        case (cfg_index)
            hss_pkg::CFG_ROW_COUNT: cfg_hit = cfg_we;
            hss_pkg::CFG_COL_COUNT: cfg_hit = cfg_we;
            hss_pkg::CFG_CFL_COEFF: cfg_hit = cfg_we;
            default:                cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= hss_pkg::ROW_COUNT_RST;
            col_count_reg <= hss_pkg::COL_COUNT_RST;
            cfl_coeff_reg <= hss_pkg::CFL_COEFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hss_pkg::CFG_ROW_COUNT:
                    row_count_reg <= cfg_data[hss_pkg::ROWCNT_W-1:0];
                hss_pkg::CFG_COL_COUNT:
                    col_count_reg <= cfg_data[hss_pkg::COLCNT_W-1:0];
                hss_pkg::CFG_CFL_COEFF:
                    cfl_coeff_reg <= cfg_data[hss_pkg::CFL_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Grid size clamped to the supported range; only the last index is kept.
    logic [hss_pkg::ROWCNT_W-1:0] rows_eff;
    logic [COL_W:0]               cols_eff;
    logic [ROW_W-1:0]             rows_m1;
    logic [COL_W-1:0]             cols_m1;

    always_comb
    begin
        if (32'(row_count_reg) < hss_pkg::MIN_DIM)
        begin
            rows_eff = hss_pkg::ROWCNT_W'(hss_pkg::MIN_DIM);
        end
        else if (32'(row_count_reg) > hss_pkg::MAX_ROWS)
        begin
            rows_eff = hss_pkg::ROWCNT_W'(hss_pkg::MAX_ROWS);
        end
        else
        begin
            rows_eff = row_count_reg;
        end

        if (32'(col_count_reg) < hss_pkg::MIN_DIM)
        begin
            cols_eff = (COL_W+1)'(hss_pkg::MIN_DIM);
        end
        else if (32'(col_count_reg) > hss_pkg::MAX_COLS)
        begin
            cols_eff = (COL_W+1)'(hss_pkg::MAX_COLS);
        end
        else
        begin
            cols_eff = (COL_W+1)'(col_count_reg);
        end

        rows_m1 = ROW_W'(rows_eff - hss_pkg::ROWCNT_W'(1));
        cols_m1 = COL_W'(cols_eff - (COL_W+1)'(1));
    end

    // ------------------------------------------------------------------
    // Input side: position counters and line stores.
    // ------------------------------------------------------------------
    logic             accept;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;
    logic             last_row, last_col;

    assign accept   = in_valid && !in_stall;
    assign last_row = (row_pos_reg == rows_m1);
    assign last_col = (col_pos_reg == cols_m1);

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_hit)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + ROW_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // The read addresses follow the next position, so the operands for the
    // next cell are ready in the cycle it may arrive. The older store is read
    // at the cell's own column, the recent store one column ahead.
    logic [TEMP_W-1:0] older_rd_data, recent_rd_data;
    logic [COL_W-1:0]  recent_rd_addr;

    assign recent_rd_addr = col_pos_next + COL_W'(1);

    // Window registers on the row above: the value at this column comes from
    // the previous beat's look-ahead read, the one to the left from the beat
    // before, and the start of each row from a register of its own.
    logic signed [TEMP_W-1:0] rhold_reg, left_reg, first_reg;
    logic signed [TEMP_W-1:0] mid, up, rt;

    assign up  = $signed(older_rd_data);
    assign rt  = $signed(recent_rd_data);
    assign mid = (col_pos_reg == '0) ? first_reg : rhold_reg;

    hss_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (hss_pkg::MAX_COLS)
    ) u_older_row_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_pos_reg),
        .wr_data (mid),
        .rd_addr (col_pos_next),
        .rd_data (older_rd_data)
    );

    hss_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (hss_pkg::MAX_COLS)
    ) u_recent_row_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_pos_reg),
        .wr_data (cell_temp),
        .rd_addr (recent_rd_addr),
        .rd_data (recent_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg  <= mid;
            rhold_reg <= rt;
            if (col_pos_reg == '0)
            begin
                first_reg <= cell_temp;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: operand register.
    // ------------------------------------------------------------------
    logic                     emit_up, emit_self, interior;
    logic [1:0]               n_results;

    assign emit_up   = (row_pos_reg != '0);
    assign emit_self = last_row;
    assign interior  = (row_pos_reg >= ROW_W'(2)) && (col_pos_reg != '0) && !last_col;
    assign n_results = {1'b0, emit_up} + {1'b0, emit_self};

    logic                     s1_valid_reg;
    logic                     s1_emit_up_reg, s1_emit_self_reg, s1_interior_reg;
    logic                     s1_last_col_reg;
    logic signed [TEMP_W-1:0] s1_u_reg, s1_up_reg, s1_dn_reg, s1_lf_reg, s1_rt_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [COL_W-1:0]         s1_col_reg;

    always_ff @(posedge clk)
    begin
        s1_emit_up_reg   <= emit_up;
        s1_emit_self_reg <= emit_self;
        s1_interior_reg  <= interior;
        s1_last_col_reg  <= last_col;
        s1_u_reg         <= mid;
        s1_up_reg        <= up;
        s1_dn_reg        <= cell_temp;
        s1_lf_reg        <= left_reg;
        s1_rt_reg        <= rt;
        s1_row_reg       <= row_pos_reg;
        s1_col_reg       <= col_pos_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: Laplacian sum up + down + left + right - 4u.
    // ------------------------------------------------------------------
    logic                     s2_valid_reg;
    logic                     s2_emit_up_reg, s2_emit_self_reg, s2_interior_reg;
    logic                     s2_last_col_reg;
    logic signed [SUM_W-1:0]  s2_sum_reg;
    logic signed [TEMP_W-1:0] s2_u_reg, s2_dn_reg;
    logic [ROW_W-1:0]         s2_row_reg;
    logic [COL_W-1:0]         s2_col_reg;

    always_ff @(posedge clk)
    begin
        s2_sum_reg       <= SUM_W'(s1_up_reg) + SUM_W'(s1_dn_reg)
                          + SUM_W'(s1_lf_reg) + SUM_W'(s1_rt_reg)
                          - (SUM_W'(s1_u_reg) <<< hss_pkg::CENTER_SHIFT);
        s2_emit_up_reg   <= s1_emit_up_reg;
        s2_emit_self_reg <= s1_emit_self_reg;
        s2_interior_reg  <= s1_interior_reg;
        s2_last_col_reg  <= s1_last_col_reg;
        s2_u_reg         <= s1_u_reg;
        s2_dn_reg        <= s1_dn_reg;
        s2_row_reg       <= s1_row_reg;
        s2_col_reg       <= s1_col_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: product with the coefficient.
    // ------------------------------------------------------------------
    logic signed [hss_pkg::CFL_W:0] cfl_s;
    assign cfl_s = $signed({1'b0, cfl_coeff_reg});

    logic                     s3_valid_reg;
    logic                     s3_emit_up_reg, s3_emit_self_reg, s3_interior_reg;
    logic                     s3_last_col_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic signed [TEMP_W-1:0] s3_u_reg, s3_dn_reg;
    logic [ROW_W-1:0]         s3_row_reg;
    logic [COL_W-1:0]         s3_col_reg;

    always_ff @(posedge clk)
    begin
        s3_prod_reg      <= PROD_W'(s2_sum_reg) * PROD_W'(cfl_s);
        s3_emit_up_reg   <= s2_emit_up_reg;
        s3_emit_self_reg <= s2_emit_self_reg;
        s3_interior_reg  <= s2_interior_reg;
        s3_last_col_reg  <= s2_last_col_reg;
        s3_u_reg         <= s2_u_reg;
        s3_dn_reg        <= s2_dn_reg;
        s3_row_reg       <= s2_row_reg;
        s3_col_reg       <= s2_col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Round to nearest (ties upward), take the floor of the shifted value,
    // add the center and clamp to the 32-bit range.
    logic signed [PROD_W-1:0] rounded;
    logic signed [QUO_W-1:0]  quotient;
    logic signed [RES_W-1:0]  res_wide;
    logic signed [TEMP_W-1:0] res_sat;

    always_comb
    begin
        rounded  = s3_prod_reg + hss_pkg::ROUND_HALF;
        quotient = $signed(rounded[PROD_W-1:hss_pkg::FRAC_W]);
        res_wide = RES_W'(s3_u_reg) + RES_W'(quotient);
        if (res_wide > hss_pkg::TEMP_MAX)
        begin
            res_sat = TEMP_W'(hss_pkg::TEMP_MAX);
        end
        else if (res_wide < hss_pkg::TEMP_MIN)
        begin
            res_sat = TEMP_W'(hss_pkg::TEMP_MIN);
        end
        else
        begin
            res_sat = TEMP_W'(res_wide);
        end
    end

    hss_pkg::result_t up_item, self_item;

    always_comb
    begin
        up_item.temp      = s3_interior_reg ? res_sat : s3_u_reg;
        up_item.row       = s3_row_reg - ROW_W'(1);
        up_item.col       = s3_col_reg;
        up_item.run_end   = !s3_emit_self_reg;
        up_item.frame_end = 1'b0;

        self_item.temp      = s3_dn_reg;
        self_item.row       = s3_row_reg;
        self_item.col       = s3_col_reg;
        self_item.run_end   = 1'b1;
        self_item.frame_end = s3_last_col_reg;
    end

    // ------------------------------------------------------------------
    // Result queue: up to two writes and one read per cycle.
    // ------------------------------------------------------------------
    hss_pkg::result_t fifo_reg [hss_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next, reserved_reg, reserved_next;
    logic             wr0_en, wr1_en, pop;
    logic [PTR_W-1:0] wr1_addr;
    logic [1:0]       n_writes;
    logic [1:0]       n_accepted;

    assign wr0_en     = s3_valid_reg && s3_emit_up_reg;
    assign wr1_en     = s3_valid_reg && s3_emit_self_reg;
    assign wr1_addr   = wr0_en ? wptr_reg + PTR_W'(1) : wptr_reg;
    assign n_writes   = {1'b0, wr0_en} + {1'b0, wr1_en};
    assign n_accepted = accept ? n_results : 2'd0;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;

    // Room is reserved for every result still in flight, so a beat is only
    // taken when the queue can hold the most it could produce.
    assign in_stall = (reserved_reg > CNT_W'(hss_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wptr_next     = wptr_reg + PTR_W'(n_writes);
        rptr_next     = rptr_reg + PTR_W'(pop);
        count_next    = count_reg + CNT_W'(n_writes) - CNT_W'(pop);
        reserved_next = reserved_reg + CNT_W'(n_accepted) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            count_reg    <= '0;
            reserved_reg <= '0;
        end
        else
        begin
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            count_reg    <= count_next;
            reserved_reg <= reserved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0_en)
        begin
            fifo_reg[wptr_reg] <= up_item;
        end
        if (wr1_en)
        begin
            fifo_reg[wr1_addr] <= self_item;
        end
    end

    hss_pkg::result_t head;
    assign head = fifo_reg[rptr_reg];

    assign new_temp  = head.temp;
    assign row_index = head.row;
    assign col_index = head.col;
    assign run_end   = head.run_end;
    assign frame_end = head.frame_end;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the heat stencil sweep: hand-checked grids, then random sweeps.
`timescale 1ns / 1ps

module tb_top;

    localparam int TEMP_W     = hss_pkg::TEMP_W;
    localparam int FRAC_W     = hss_pkg::FRAC_W;
    localparam int ROW_W      = hss_pkg::ROW_W;
    localparam int COL_W      = hss_pkg::COL_W;
    localparam int ROWCNT_W   = hss_pkg::ROWCNT_W;
    localparam int COLCNT_W   = hss_pkg::COLCNT_W;
    localparam int CFL_W      = hss_pkg::CFL_W;
    localparam int CFG_IDX_W  = hss_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = hss_pkg::CFG_DATA_W;
    localparam int MAX_COLS   = hss_pkg::MAX_COLS;
    localparam int MAX_ROWS   = hss_pkg::MAX_ROWS;
    localparam int MIN_DIM    = hss_pkg::MIN_DIM;

    typedef logic signed [TEMP_W-1:0] temp_t;

    // Extremes of a Q16.16 temperature, and the fixed-point pieces of the update.
    localparam temp_t  TEMP_TOP      = 32'sh7FFF_FFFF;
    localparam temp_t  TEMP_BOTTOM   = 32'sh8000_0000;
    localparam longint CENTER_WEIGHT = 4;
    localparam longint ROUND_BIAS    = longint'(1) << (FRAC_W - 1);

    // Register index that the block must ignore completely.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // This margin covers first-row beats, which are still in flight when the
    // last expected result has arrived.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 500;

    // About 600 input beats in total. The limit leaves ample room even with
    // every beat yielding two results that each sit out the longest stall plus
    // sender gaps.
    localparam int TIME_LIMIT_NS = 20_000_000;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    temp_t                    cell_temp = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    temp_t                    new_temp;
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         col_index;
    logic                     run_end;
    logic                     frame_end;

    heat_stencil_sweep DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cell_temp (cell_temp),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .new_temp  (new_temp),
        .row_index (row_index),
        .col_index (col_index),
        .run_end   (run_end),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops beats.
    initial
    begin
        #(TIME_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sweep predictor: its own copy of the registers, the two line stores
    // and the raster position. Unwritten store entries only ever feed
    // border cells, so their reset value is irrelevant.
    // ------------------------------------------------------------------
    logic [ROWCNT_W-1:0] rows_reg = hss_pkg::ROW_COUNT_RST;
    logic [COLCNT_W-1:0] cols_reg = hss_pkg::COL_COUNT_RST;
    logic [CFL_W-1:0]    cfl_reg  = hss_pkg::CFL_COEFF_RST;
    temp_t               upper_line [MAX_COLS] = '{default: '0};
    temp_t               near_line  [MAX_COLS] = '{default: '0};
    int                  grid_row = 0;
    int                  grid_col = 0;
    hss_pkg::result_t    cell_results [2];

    // Results still owed by the block, oldest first.
    hss_pkg::result_t    expected_beats [$];
    int                  fault_count = 0;

    // Out-of-range sizes act as the nearest legal size.
    function automatic int clamp_dim(int value, int upper);
        if (value < MIN_DIM)
            return MIN_DIM;
        if (value > upper)
            return upper;
        return value;
    endfunction

    // u + cfl * (up + down + left + right - 4u), rounded half up and
    // saturated. An arithmetic shift of a 64-bit value is a true floor.
    function automatic temp_t relax_cell(temp_t u, temp_t up, temp_t dn, temp_t lf, temp_t rt);
        longint lap;
        longint scaled;
        longint total;
        lap = longint'(up) + longint'(dn) + longint'(lf) + longint'(rt)
              - CENTER_WEIGHT * longint'(u);
        scaled = (lap * longint'(cfl_reg) + ROUND_BIAS) >>> FRAC_W;
        total = longint'(u) + scaled;
        if (total > longint'(TEMP_TOP))
            return TEMP_TOP;
        if (total < longint'(TEMP_BOTTOM))
            return TEMP_BOTTOM;
        return temp_t'(total);
    endfunction

    // Takes one grid cell and fills cell_results with the beats it causes.
    function automatic int advance_grid(temp_t incoming);
        int               rows;
        int               cols;
        int               r;
        int               c;
        int               n;
        bit               last_row;
        bit               last_col;
        temp_t            two_above;
        temp_t            one_above;
        hss_pkg::result_t beat;
        rows = clamp_dim(int'(rows_reg), MAX_ROWS);
        cols = clamp_dim(int'(cols_reg), MAX_COLS);
        r = (grid_row >= rows) ? rows - 1 : grid_row;
        c = (grid_col >= cols) ? cols - 1 : grid_col;
        last_row = (r == rows - 1);
        last_col = (c == cols - 1);
        n = 0;

        two_above = upper_line[c];
        one_above = near_line[c];
        upper_line[c] = one_above;
        near_line[c] = incoming;

        // Every row but the first finishes the cell directly above it. By
        // now the left neighbor of that cell has moved to the upper line.
        if (r >= 1)
        begin
            beat.temp = one_above;
            if (r >= 2 && c >= 1 && !last_col)
                beat.temp = relax_cell(one_above, two_above, incoming,
                                       upper_line[c - 1], near_line[c + 1]);
            beat.row = ROW_W'(r - 1);
            beat.col = COL_W'(c);
            beat.run_end = !last_row;
            beat.frame_end = 1'b0;
            cell_results[n] = beat;
            n++;
        end
        // The bottom row is a border, so it also passes itself through.
        if (last_row)
        begin
            beat.temp = incoming;
            beat.row = ROW_W'(r);
            beat.col = COL_W'(c);
            beat.run_end = 1'b1;
            beat.frame_end = last_col;
            cell_results[n] = beat;
            n++;
        end

        c++;
        if (c >= cols)
        begin
            c = 0;
            r++;
            if (r >= rows)
                r = 0;
        end
        grid_row = r;
        grid_col = c;
        return n;
    endfunction

    // Any write to a real register also restarts the frame.
    function automatic void note_register(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] value);
        case (idx)
            hss_pkg::CFG_ROW_COUNT: rows_reg = value[ROWCNT_W-1:0];
            hss_pkg::CFG_COL_COUNT: cols_reg = value[COLCNT_W-1:0];
            hss_pkg::CFG_CFL_COEFF: cfl_reg = value[CFL_W-1:0];
            default: return;
        endcase
        grid_row = 0;
        grid_col = 0;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stalls follow a pattern whose mode changes at random intervals,
    // from no stalls at all to long stretches of back-pressure.
    // ------------------------------------------------------------------
    typedef enum int {STALL_OFF, STALL_COIN, STALL_RUNS, STALL_RARE} stall_mode_t;

    stall_mode_t stall_mode = STALL_OFF;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          run_level  = 1'b0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 300);
        end
        else
            mode_left--;

        case (stall_mode)
            STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
            STALL_RUNS:
            begin
                if (hold_left == 0)
                begin
                    run_level = !run_level;
                    hold_left = $urandom_range(1, 20);
                end
                hold_left--;
                out_stall <= run_level;
            end
            STALL_RARE: out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= 1'b0;
        endcase
    end

    // Every accepted result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        hss_pkg::result_t seen;
        hss_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.temp = new_temp;
            seen.row = row_index;
            seen.col = col_index;
            seen.run_end = run_end;
            seen.frame_end = frame_end;
            if (expected_beats.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected result beat: temp %0d row %0d col %0d",
                             seen.temp, seen.row, seen.col);
                fault_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (seen.temp !== want.temp || seen.row !== want.row ||
                    seen.col !== want.col || seen.run_end !== want.run_end ||
                    seen.frame_end !== want.frame_end)
                begin
                    if (fault_count < 10)
                        $display("mismatch: expected temp %0d row %0d col %0d run %0b frame %0b, got temp %0d row %0d col %0d run %0b frame %0b",
                                 want.temp, want.row, want.col, want.run_end,
                                 want.frame_end, seen.temp, seen.row, seen.col,
                                 seen.run_end, seen.frame_end);
                    fault_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Offers one cell and waits until it is taken. Beats come in bursts of
    // random length; some bursts are long, with no gaps at all. A row of the
    // hand-checked script overrides the predicted temperatures with its own.
    task automatic send_cell(input temp_t value, input bit by_hand,
                             input temp_t hand0, input temp_t hand1);
        int               gap;
        int               n;
        hss_pkg::result_t beat;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(30, 120);
            else
                burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cell_temp <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        n = advance_grid(value);
        for (int k = 0; k < n; k++)
        begin
            beat = cell_results[k];
            if (by_hand)
                beat.temp = (k == 0) ? hand0 : hand1;
            expected_beats.push_back(beat);
        end
    endtask

    // Stops sending and waits until the block has delivered everything owed,
    // then gives first-row beats time to leave the pipeline.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes go back to back; the last one of a group drops the enable.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value,
                                  input bit last_write);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (last_write)
            cfg_we <= 1'b0;
        note_register(idx, value);
    endtask

    function automatic temp_t random_temp();
        case ($urandom_range(0, 9))
            0: return TEMP_TOP;
            1: return TEMP_BOTTOM;
            2, 3, 4: return temp_t'($urandom);
            default: return temp_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    // Small grids keep frames short; sizes below the minimum and junk above
    // the register width show up now and then.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(int which);
        logic [CFG_DATA_W-1:0] v;
        if (which == hss_pkg::CFG_ROW_COUNT)
        begin
            v = CFG_DATA_W'($urandom_range(0, 8));
            if ($urandom_range(0, 3) == 0)
                v = v | (CFG_DATA_W'($urandom) << ROWCNT_W);
        end
        else if (which == hss_pkg::CFG_COL_COUNT)
        begin
            v = CFG_DATA_W'($urandom_range(0, 10));
            if ($urandom_range(0, 3) == 0)
                v = v | (CFG_DATA_W'($urandom) << COLCNT_W);
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = '1;
                2: v = hss_pkg::CFL_COEFF_RST;
                3: v = CFG_DATA_W'($urandom_range(0, 16384));
                default: v = CFG_DATA_W'($urandom_range(0, 65535));
            endcase
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Hand-checked grids, 3 rows by 4 columns (a row count of zero acts as
    // three). Only the two middle cells of row 1 are interior.
    //
    // Grid one, full coefficient: the interior cells sit at opposite
    // extremes from all their neighbors, so both clamp, one high, one low.
    // Grid two, coefficient one half: the neighbor sums are +1 and -1, which
    // land exactly on a rounding tie; ties go up, giving 1 and 0.
    // Row 0 produces nothing, row 1 passes row 0 through, and row 2 emits
    // row 1 and then itself.
    // ------------------------------------------------------------------
    typedef enum bit {STEP_CELL, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        temp_t                 grid_value;
        temp_t                 hand0;
        temp_t                 hand1;
    } script_step_t;

    script_step_t directed_script [28] = '{
        '{STEP_WRITE, hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd0,        32'sd0,      32'sd0},
        '{STEP_WRITE, hss_pkg::CFG_COL_COUNT, 16'd4,    32'sd0,        32'sd0,      32'sd0},
        '{STEP_WRITE, hss_pkg::CFG_CFL_COEFF, 16'hFFFF, 32'sd0,        32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd0,        32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    TEMP_TOP,      32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    TEMP_BOTTOM,   32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    -32'sd1,       32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    TEMP_TOP,      32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    TEMP_BOTTOM,   TEMP_TOP,    32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    TEMP_TOP,      TEMP_BOTTOM, 32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    TEMP_BOTTOM,   -32'sd1,     32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd1,        TEMP_TOP,    32'sd1},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    TEMP_TOP,      TEMP_TOP,    TEMP_TOP},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    TEMP_BOTTOM,   TEMP_BOTTOM, TEMP_BOTTOM},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sh12345678, TEMP_BOTTOM, 32'sh12345678},
        '{STEP_WRITE, hss_pkg::CFG_CFL_COEFF, 16'h8000, 32'sd0,        32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd5,        32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd1,        32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    -32'sd1,       32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd7,        32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd0,        32'sd5,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd0,        32'sd1,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd0,        -32'sd1,     32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd0,        32'sd7,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd9,        32'sd0,      32'sd9},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd0,        32'sd1,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    32'sd0,        32'sd0,      32'sd0},
        '{STEP_CELL,  hss_pkg::CFG_ROW_COUNT, 16'd0,    -32'sd9,       32'sd0,      -32'sd9}
    };

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int                    phase;
        int                    cells;
        int                    area;
        int                    mask;
        int                    random_count;
        int                    waited;
        bit                    last_write;
        logic [CFG_DATA_W-1:0] value;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the hand-checked script. Each group of writes waits for the
        // block to go idle first.
        foreach (directed_script[i])
        begin
            if (directed_script[i].kind == STEP_WRITE)
            begin
                if (i == 0)
                    settle();
                else if (directed_script[i - 1].kind != STEP_WRITE)
                    settle();
                last_write = 1'b1;
                if (i + 1 < $size(directed_script))
                    last_write = (directed_script[i + 1].kind != STEP_WRITE);
                write_register(directed_script[i].idx, directed_script[i].value, last_write);
            end
            else
                send_cell(directed_script[i].grid_value, 1'b1,
                          directed_script[i].hand0, directed_script[i].hand1);
        end

        // Random sweeps. Most phases stream whole frames of random content
        // over a small grid; some stop partway. Two short phases push the
        // width and the height past their clamped maximum.
        random_count = 0;
        phase = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            settle();
            if (phase == 3)
            begin
                // A column count above the store depth acts as the full
                // depth, so no row ends within this short stretch.
                write_register(hss_pkg::CFG_ROW_COUNT, 16'd3, 1'b0);
                write_register(hss_pkg::CFG_COL_COUNT, 16'd2047, 1'b1);
                cells = 40;
            end
            else if (phase == 6)
            begin
                write_register(hss_pkg::CFG_ROW_COUNT, 16'h1FFF, 1'b0);
                write_register(hss_pkg::CFG_COL_COUNT, 16'd3, 1'b1);
                cells = 40;
            end
            else
            begin
                if (phase == 0)
                    mask = 7;
                else if (phase == 1)
                    mask = 4;
                else
                    mask = $urandom_range(0, 7);
                for (int r = 0; r < 3; r++)
                begin
                    if (mask[r])
                    begin
                        if (phase == 1)
                            value = '0;
                        else
                            value = pick_setting(r);
                        write_register(CFG_IDX_W'(r), value, (mask >> (r + 1)) == 0);
                    end
                end
                area = clamp_dim(int'(rows_reg), MAX_ROWS) * clamp_dim(int'(cols_reg), MAX_COLS);
                if ($urandom_range(0, 3) == 0)
                    cells = $urandom_range(1, area + 5);
                else
                    cells = area * $urandom_range(1, 3);
            end

            for (int k = 0; k < cells; k++)
            begin
                // Now and then hold off until the block has emptied, and
                // sometimes poke the unused register index, which must not
                // disturb the frame in progress.
                if ($urandom_range(0, 49) == 0)
                begin
                    settle();
                    if ($urandom_range(0, 1) == 1)
                        write_register(CFG_SPARE_INDEX, CFG_DATA_W'($urandom), 1'b1);
                end
                send_cell(random_temp(), 1'b0, '0, '0);
                random_count++;
            end
            phase++;
        end

        // Drain what is still owed, with a bound, then let the pipeline go
        // quiet so that any extra beat is caught.
        in_valid <= 1'b0;
        waited = 0;
        while (expected_beats.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            if (fault_count < 10)
                $display("%0d expected result beats never arrived", expected_beats.size());
            fault_count += expected_beats.size();
        end

        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/hss_pkg.sv
design/hss_ram.sv
design/heat_stencil_sweep.sv
dv/tb_top.sv
